// ----- rtl/lfu_cache_policy_core_defines.svh -----
// assertion macros for the lfu cache policy core checker
`ifndef LFU_CACHE_POLICY_CORE_DEFINES_SVH
`define LFU_CACHE_POLICY_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk of the using scope, off while rst_n is low
`define LCP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lfu cache policy check failed");

// next-cycle implication, sampled on clk of the using scope, off while rst_n is low
`define LCP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lfu cache policy check failed");

`endif

// ----- rtl/lcp_pkg.sv -----
// shared constants, codes and control types of the lfu cache policy core
package lcp_pkg;

  localparam int ENTRIES    = 16;
  localparam int KEY_BITS   = 16;
  localparam int COUNT_BITS = 16;
  localparam int VALUE_BITS = 32;
  localparam int CAP_BITS   = 5;

  localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

  // slot index, fill count and capacity compare widths
  localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W  = $clog2(ENTRIES + 1);
  localparam int CMP_W  = (CAP_BITS > OCC_W) ? CAP_BITS : OCC_W;

  // victim search: groups reduced in the first step, group winners in the second
  localparam int GROUP   = 4;
  localparam int NGROUPS = (ENTRIES + GROUP - 1) / GROUP;
  localparam int SCORE_W = 1 + COUNT_BITS + SLOT_W;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam logic MODE_PUT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SELECT,
    ST_UPDATE
  } state_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_TOUCH,
    ACT_INSERT,
    ACT_EVICT
  } action_t;

  typedef struct packed {
    logic    load;
    logic    lookup;
    logic    select;
    logic    update;
    action_t action;
  } cmd_t;

  typedef struct packed {
    logic is_put;
    logic hit;
    logic room;
    logic cap_zero;
  } stat_t;

endpackage

// ----- rtl/lcp_channels.sv -----
// request, response and configuration channel interfaces
interface lcp_req_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   mode;
  logic        [lcp_pkg::KEY_BITS-1:0]    key;
  logic signed [lcp_pkg::VALUE_BITS-1:0]  value;

  modport source (output valid, mode, key, value, input ready);
  modport sink   (input valid, mode, key, value, output ready);
endinterface

interface lcp_rsp_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   hit;
  logic signed [lcp_pkg::VALUE_BITS-1:0]  read_value;
  logic                                   evicted;
  logic        [lcp_pkg::KEY_BITS-1:0]    evicted_key;

  modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
  modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

interface lcp_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [lcp_pkg::CAP_BITS-1:0]    capacity;

  modport source (output valid, capacity, input ready);
  modport sink   (input valid, capacity, output ready);
endinterface

// ----- rtl/lcp_ctrl.sv -----
// sequencing state machine: request intake, lookup, victim select, update
module lcp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  lcp_pkg::stat_t stat,
  output lcp_pkg::cmd_t  cmd
);

  lcp_pkg::state_t  state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  lcp_pkg::action_t action;

  // state and response valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lcp_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // what the update step does, from the lookup outcome
  always_comb begin
    if (!stat.is_put) begin
      action = stat.hit ? lcp_pkg::ACT_TOUCH : lcp_pkg::ACT_NONE;
    end else if (stat.cap_zero) begin
      action = lcp_pkg::ACT_NONE;
    end else if (stat.hit) begin
      action = lcp_pkg::ACT_TOUCH;
    end else if (stat.room) begin
      action = lcp_pkg::ACT_INSERT;
    end else begin
      action = lcp_pkg::ACT_EVICT;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    cmd.load      = 1'b0;
    cmd.lookup    = 1'b0;
    cmd.select    = 1'b0;
    cmd.update    = 1'b0;
    cmd.action    = action;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      lcp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = lcp_pkg::ST_LOOKUP;
        end
      end
      lcp_pkg::ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_nxt  = lcp_pkg::ST_SELECT;
      end
      lcp_pkg::ST_SELECT: begin
        cmd.select = 1'b1;
        state_nxt  = lcp_pkg::ST_UPDATE;
      end
      lcp_pkg::ST_UPDATE: begin
        // commit only once the response register is free
        if (!out_valid_r || out_ready) begin
          cmd.update    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = lcp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lcp_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ----- rtl/lcp_datapath.sv -----
// entry storage, parallel key match, victim search and entry update
module lcp_datapath (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_mode,
  input  logic        [lcp_pkg::KEY_BITS-1:0]   in_key,
  input  logic signed [lcp_pkg::VALUE_BITS-1:0] in_value,
  input  logic                                  cfg_valid,
  input  logic        [lcp_pkg::CAP_BITS-1:0]   cfg_capacity,
  input  lcp_pkg::cmd_t                         cmd,
  output lcp_pkg::stat_t                        stat,
  output logic                                  out_hit,
  output logic signed [lcp_pkg::VALUE_BITS-1:0] out_read_value,
  output logic                                  out_evicted,
  output logic        [lcp_pkg::KEY_BITS-1:0]   out_evicted_key
);

  localparam int ENTRIES = lcp_pkg::ENTRIES;
  localparam int SLOT_W  = lcp_pkg::SLOT_W;
  localparam int OCC_W   = lcp_pkg::OCC_W;
  localparam int CMP_W   = lcp_pkg::CMP_W;
  localparam int GROUP   = lcp_pkg::GROUP;
  localparam int NGROUPS = lcp_pkg::NGROUPS;
  localparam int SCORE_W = lcp_pkg::SCORE_W;
  localparam int KB      = lcp_pkg::KEY_BITS;
  localparam int VB      = lcp_pkg::VALUE_BITS;
  localparam int CB      = lcp_pkg::COUNT_BITS;

  // configuration and fill count
  logic [lcp_pkg::CAP_BITS-1:0] capacity_r;
  logic [OCC_W-1:0]             occupied_r;

  // captured request
  logic                 mode_r;
  logic        [KB-1:0] key_r;
  logic signed [VB-1:0] value_r;

  // entry storage
  logic        [KB-1:0]     entry_key_r   [ENTRIES];
  logic signed [VB-1:0]     entry_value_r [ENTRIES];
  logic        [CB-1:0]     use_count_r   [ENTRIES];
  logic        [SLOT_W-1:0] rank_r        [ENTRIES];

  // pipeline of one request
  logic                 hit_r;
  logic [SLOT_W-1:0]    hit_slot_r;
  logic [SCORE_W-1:0]   grp_score_r [NGROUPS];
  logic [SLOT_W-1:0]    grp_slot_r  [NGROUPS];
  logic [SLOT_W-1:0]    victim_r;
  logic signed [VB-1:0] rd_r;

  // response register
  logic                 out_hit_r;
  logic signed [VB-1:0] out_read_value_r;
  logic                 out_evicted_r;
  logic        [KB-1:0] out_evicted_key_r;

  logic [ENTRIES-1:0] slot_valid;
  logic [SCORE_W-1:0] score [ENTRIES];
  logic               match_any;
  logic [SLOT_W-1:0]  match_slot;
  logic [SCORE_W-1:0] grp_score_nxt [NGROUPS];
  logic [SLOT_W-1:0]  grp_slot_nxt  [NGROUPS];
  logic [SLOT_W-1:0]  victim_nxt;
  logic [CMP_W-1:0]   cap_ext;
  logic [CMP_W-1:0]   cap_eff;
  logic [SLOT_W-1:0]  tgt;
  logic [OCC_W-1:0]   rank_ref;
  logic [SLOT_W-1:0]  rank_nxt  [ENTRIES];
  logic [CB-1:0]      count_nxt [ENTRIES];
  logic               do_update;
  logic               is_evict;

  // slot validity and victim score: invalid last, then low count, then old rank
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      slot_valid[i] = OCC_W'(i) < occupied_r;
      score[i]      = {!slot_valid[i], use_count_r[i], ~rank_r[i]};
    end
  end

  // parallel key compare, valid keys are unique so the match index is an or
  always_comb begin
    match_any  = 1'b0;
    match_slot = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_valid[i] && (entry_key_r[i] == key_r)) begin
        match_any  = 1'b1;
        match_slot = match_slot | SLOT_W'(i);
      end
    end
  end

  // victim search, first step: minimum within each group
  always_comb begin
    int idx;
    for (int g = 0; g < NGROUPS; g++) begin
      grp_score_nxt[g] = score[g * GROUP];
      grp_slot_nxt[g]  = SLOT_W'(g * GROUP);
      for (int j = 1; j < GROUP; j++) begin
        idx = g * GROUP + j;
        if (idx < ENTRIES) begin
          if (score[idx] < grp_score_nxt[g]) begin
            grp_score_nxt[g] = score[idx];
            grp_slot_nxt[g]  = SLOT_W'(idx);
          end
        end
      end
    end
  end

  // victim search, second step: minimum over the group winners
  always_comb begin
    logic [SCORE_W-1:0] best;
    best       = grp_score_r[0];
    victim_nxt = grp_slot_r[0];
    for (int g = 1; g < NGROUPS; g++) begin
      if (grp_score_r[g] < best) begin
        best       = grp_score_r[g];
        victim_nxt = grp_slot_r[g];
      end
    end
  end

  // status for the controller
  always_comb begin
    cap_ext       = CMP_W'(capacity_r);
    cap_eff       = (cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext;
    stat.is_put   = (mode_r == lcp_pkg::MODE_PUT);
    stat.hit      = hit_r;
    stat.room     = CMP_W'(occupied_r) < cap_eff;
    stat.cap_zero = (capacity_r == '0);
  end

  // target slot and recency reference of the update
  always_comb begin
    case (cmd.action)
      lcp_pkg::ACT_TOUCH: tgt = hit_slot_r;
      lcp_pkg::ACT_EVICT: tgt = victim_r;
      default:            tgt = occupied_r[SLOT_W-1:0];
    endcase
    if (cmd.action == lcp_pkg::ACT_INSERT) begin
      rank_ref = occupied_r;
    end else begin
      rank_ref = OCC_W'(rank_r[tgt]);
    end
    do_update = cmd.update && (cmd.action != lcp_pkg::ACT_NONE);
    is_evict  = (cmd.action == lcp_pkg::ACT_EVICT);
  end

  // per slot rank aging and count update
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      rank_nxt[i]  = rank_r[i];
      count_nxt[i] = use_count_r[i];
      if (slot_valid[i] && (OCC_W'(rank_r[i]) < rank_ref)) begin
        rank_nxt[i] = rank_r[i] + 1'b1;
      end
      if (SLOT_W'(i) == tgt) begin
        rank_nxt[i] = '0;
        if (cmd.action == lcp_pkg::ACT_TOUCH) begin
          if (use_count_r[i] != lcp_pkg::COUNT_MAX) begin
            count_nxt[i] = use_count_r[i] + 1'b1;
          end
        end else begin
          count_nxt[i] = CB'(1);
        end
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= lcp_pkg::CAP_RESET;
      occupied_r <= '0;
    end else begin
      if (cfg_valid) begin
        capacity_r <= cfg_capacity;
      end
      if (cmd.update && (cmd.action == lcp_pkg::ACT_INSERT)) begin
        occupied_r <= occupied_r + 1'b1;
      end
    end
  end

  // request capture and per-step pipeline registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= in_mode;
      key_r   <= in_key;
      value_r <= in_value;
    end
    if (cmd.lookup) begin
      hit_r      <= match_any;
      hit_slot_r <= match_slot;
      for (int g = 0; g < NGROUPS; g++) begin
        grp_score_r[g] <= grp_score_nxt[g];
        grp_slot_r[g]  <= grp_slot_nxt[g];
      end
    end
    if (cmd.select) begin
      victim_r <= victim_nxt;
      rd_r     <= entry_value_r[hit_slot_r];
    end
  end

  // entry writes
  always_ff @(posedge clk) begin
    if (do_update) begin
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i]      <= rank_nxt[i];
        use_count_r[i] <= count_nxt[i];
      end
      if (cmd.action != lcp_pkg::ACT_TOUCH) begin
        entry_key_r[tgt] <= key_r;
      end
      if (mode_r == lcp_pkg::MODE_PUT) begin
        entry_value_r[tgt] <= value_r;
      end
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_hit_r         <= hit_r;
      out_read_value_r  <= ((mode_r != lcp_pkg::MODE_PUT) && hit_r) ? rd_r : '0;
      out_evicted_r     <= is_evict;
      out_evicted_key_r <= is_evict ? entry_key_r[victim_r] : '0;
    end
  end

  assign out_hit         = out_hit_r;
  assign out_read_value  = out_read_value_r;
  assign out_evicted     = out_evicted_r;
  assign out_evicted_key = out_evicted_key_r;

endmodule

// ----- rtl/lfu_cache_policy_core.sv -----
// top level of the lfu cache policy core
// Fully associative key-value cache, least-frequently-used replacement with
// least-recent tie break, sixteen entries held in flip-flops.
// in_req carries one get (mode 0) or put (mode 1) request of key and value.
// out_rsp returns one response per request: hit, read_value, evicted and
// evicted_key. cfg_wr writes the capacity register; it is always ready;
// the user must write it only while no request is in flight, and the
// block itself does not enforce this. The response is registered after
// the lookup, victim select and update steps, later while out_rsp stalls.
// A new request is taken only once the previous one has passed the intake
// step and the three-step sequence of key compare, two-level victim search
// and entry/rank update.
// in_req.ready is high only between requests.
// A finished response waits in the output register; the next request is
// taken meanwhile and holds in its update step until that register frees.
// Reset (rst_n low, synchronous) empties the cache and sets capacity to 16;
// there is no clearing pass, entries above the fill count are never read.
module lfu_cache_policy_core (
  input  logic       clk,
  input  logic       rst_n,
  lcp_req_if.sink    in_req,
  lcp_rsp_if.source  out_rsp,
  lcp_cfg_if.sink    cfg_wr
);

  lcp_pkg::cmd_t  cmd;
  lcp_pkg::stat_t stat;
  logic           in_ready;
  logic           out_valid;

  // sequencing
  lcp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // storage and compute
  lcp_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mode         (in_req.mode),
    .in_key          (in_req.key),
    .in_value        (in_req.value),
    .cfg_valid       (cfg_wr.valid),
    .cfg_capacity    (cfg_wr.capacity),
    .cmd             (cmd),
    .stat            (stat),
    .out_hit         (out_rsp.hit),
    .out_read_value  (out_rsp.read_value),
    .out_evicted     (out_rsp.evicted),
    .out_evicted_key (out_rsp.evicted_key)
  );

  assign in_req.ready  = in_ready;
  assign out_rsp.valid = out_valid;
  assign cfg_wr.ready  = 1'b1;

endmodule

// ----- rtl/lcp_checker.sv -----
// port-level checks of the lfu cache policy core and their bind
`include "lfu_cache_policy_core_defines.svh"

module lcp_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic                                  out_hit,
  input logic signed [lcp_pkg::VALUE_BITS-1:0] out_read_value,
  input logic                                  out_evicted,
  input logic        [lcp_pkg::KEY_BITS-1:0]   out_evicted_key
);

  // a stalled response stays up
  `LCP_ASSERT_NEXT(a_rsp_held, out_valid && !out_ready, out_valid)

  // a taken request blocks intake through lookup, select and update
  `LCP_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready ##1 !in_ready ##1 !in_ready)

  // an eviction only comes with a miss and no read data
  `LCP_ASSERT_IMPL(a_evict_is_miss, out_valid && out_evicted, !out_hit && (out_read_value == '0))

  // a miss never returns data
  `LCP_ASSERT_IMPL(a_miss_no_data, out_valid && !out_hit, out_read_value == '0)

  // no evicted key without an eviction
  `LCP_ASSERT_IMPL(a_no_stray_key, out_valid && !out_evicted, out_evicted_key == '0)

endmodule

bind lfu_cache_policy_core lcp_checker u_lcp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_req.valid),
  .in_ready        (in_req.ready),
  .out_valid       (out_rsp.valid),
  .out_ready       (out_rsp.ready),
  .out_hit         (out_rsp.hit),
  .out_read_value  (out_rsp.read_value),
  .out_evicted     (out_rsp.evicted),
  .out_evicted_key (out_rsp.evicted_key)
);

// ----- bench/tb_lfu_cache_policy_core.sv -----
// testbench of the lfu cache policy core: directed and random get/put requests against a cache mirror
`timescale 1ns / 100ps

module tb_lfu_cache_policy_core;

  localparam logic MODE_GET = ~lcp_pkg::MODE_PUT;

  typedef struct packed {
    logic                                  hit;
    logic signed [lcp_pkg::VALUE_BITS-1:0] read_value;
    logic                                  evicted;
    logic        [lcp_pkg::KEY_BITS-1:0]   evicted_key;
  } cache_rsp_t;

  // mirror of the cache contents, predicts the response of each request
  class cache_mirror;
    logic [lcp_pkg::CAP_BITS-1:0]   capacity;
    int                             occupied;
    logic [lcp_pkg::KEY_BITS-1:0]   slot_key [lcp_pkg::ENTRIES];
    logic [lcp_pkg::VALUE_BITS-1:0] slot_value [lcp_pkg::ENTRIES];
    logic [lcp_pkg::COUNT_BITS-1:0] slot_uses [lcp_pkg::ENTRIES];
    int                             slot_age [lcp_pkg::ENTRIES];
    cache_rsp_t                     expected_rsp [$];
    int                             errors;

    function new();
      capacity = lcp_pkg::CAP_RESET;
      occupied = 0;
      errors   = 0;
    endfunction

    function void set_capacity(logic [lcp_pkg::CAP_BITS-1:0] cap);
      capacity = cap;
    endfunction

    // slot s becomes the most recent, younger entries age by one
    function void promote(int s);
      int r;
      r = slot_age[s];
      for (int i = 0; i < occupied; i++) begin
        if (slot_age[i] < r) slot_age[i]++;
      end
      slot_age[s] = 0;
    endfunction

    function void bump(int s);
      if (slot_uses[s] != lcp_pkg::COUNT_MAX) slot_uses[s]++;
      promote(s);
    endfunction

    function void note_request(logic mode, logic [lcp_pkg::KEY_BITS-1:0] key,
                               logic [lcp_pkg::VALUE_BITS-1:0] value);
      cache_rsp_t rsp;
      int         cap;
      int         s;
      int         v;
      rsp = '0;
      s   = -1;
      cap = (capacity > lcp_pkg::ENTRIES) ? lcp_pkg::ENTRIES : capacity;
      for (int i = 0; i < occupied; i++) begin
        if (s < 0 && slot_key[i] == key) s = i;
      end
      rsp.hit = (s >= 0);
      if (mode == MODE_GET) begin
        if (rsp.hit) begin
          rsp.read_value = slot_value[s];
          bump(s);
        end
      end else if (cap != 0) begin
        if (rsp.hit) begin
          slot_value[s] = value;
          bump(s);
        end else if (occupied < cap) begin
          // fill the next free slot
          for (int i = 0; i < occupied; i++) slot_age[i]++;
          s = occupied;
          occupied++;
          slot_key[s]   = key;
          slot_value[s] = value;
          slot_uses[s]  = lcp_pkg::COUNT_BITS'(1);
          slot_age[s]   = 0;
        end else begin
          // lowest use count, ties go to the least recent entry
          v = 0;
          for (int i = 1; i < occupied; i++) begin
            if (slot_uses[i] < slot_uses[v] ||
                (slot_uses[i] == slot_uses[v] && slot_age[i] > slot_age[v]))
              v = i;
          end
          rsp.evicted     = 1'b1;
          rsp.evicted_key = slot_key[v];
          slot_key[v]     = key;
          slot_value[v]   = value;
          slot_uses[v]    = lcp_pkg::COUNT_BITS'(1);
          promote(v);
        end
      end
      expected_rsp.push_back(rsp);
    endfunction

    function void check_response(cache_rsp_t got);
      cache_rsp_t exp;
      if (expected_rsp.size() == 0) begin
        $error("response with no request pending");
        errors++;
        return;
      end
      exp = expected_rsp.pop_front();
      if (got.hit !== exp.hit) begin
        $error("hit: expected %0d, actual %0d", exp.hit, got.hit);
        errors++;
      end
      if (got.read_value !== exp.read_value) begin
        $error("read_value: expected %0d, actual %0d", exp.read_value, got.read_value);
        errors++;
      end
      if (got.evicted !== exp.evicted) begin
        $error("evicted: expected %0d, actual %0d", exp.evicted, got.evicted);
        errors++;
      end
      if (got.evicted_key !== exp.evicted_key) begin
        $error("evicted_key: expected 0x%04h, actual 0x%04h", exp.evicted_key,
               got.evicted_key);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic no_idle;
  int   stall_left;
  logic [lcp_pkg::KEY_BITS-1:0] hot_keys [32];
  cache_mirror mirror;

  lcp_req_if req_ch();
  lcp_rsp_if rsp_ch();
  lcp_cfg_if cfg_ch();

  lfu_cache_policy_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_ch.sink),
    .out_rsp(rsp_ch.source),
    .cfg_wr (cfg_ch.sink)
  );

  always #6 clk = ~clk;

  // idle length: mostly short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // response side stalls
  always @(posedge clk) begin
    if (stall_left > 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (!no_idle && $urandom_range(0, 99) < 25) begin
      rsp_ch.ready <= 1'b0;
      stall_left   <= idle_len();
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // monitor: accepted requests, responses and capacity writes
  always @(posedge clk) begin
    if (rst_n) begin
      if (rsp_ch.valid && rsp_ch.ready)
        mirror.check_response({rsp_ch.hit, rsp_ch.read_value, rsp_ch.evicted,
                               rsp_ch.evicted_key});
      if (req_ch.valid && req_ch.ready)
        mirror.note_request(req_ch.mode, req_ch.key, req_ch.value);
      if (cfg_ch.valid && cfg_ch.ready)
        mirror.set_capacity(cfg_ch.capacity);
    end
  end

  // one request, after a random gap; valid stays high when there is no gap
  task automatic send_request(input logic mode, input logic [lcp_pkg::KEY_BITS-1:0] key,
                              input logic [lcp_pkg::VALUE_BITS-1:0] value);
    int gap;
    gap = no_idle ? 0 : idle_len();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.mode  <= mode;
    req_ch.key   <= key;
    req_ch.value <= value;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // stop sending and wait until every response has come back
  task automatic drain();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (mirror.expected_rsp.size() != 0);
  endtask

  task automatic write_capacity(input logic [lcp_pkg::CAP_BITS-1:0] cap);
    cfg_ch.valid    <= 1'b1;
    cfg_ch.capacity <= cap;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // random requests, mostly over a small set of hot keys
  task automatic run_phase(input int n_items, input int pool_n, input int put_pct);
    logic                           mode;
    logic [lcp_pkg::KEY_BITS-1:0]   key;
    for (int i = 0; i < pool_n; i++) hot_keys[i] = lcp_pkg::KEY_BITS'($urandom_range(0, 65535));
    for (int n = 0; n < n_items; n++) begin
      mode = ($urandom_range(0, 99) < put_pct) ? lcp_pkg::MODE_PUT : MODE_GET;
      key  = ($urandom_range(0, 99) < 80) ? hot_keys[$urandom_range(0, pool_n - 1)]
                                          : lcp_pkg::KEY_BITS'($urandom_range(0, 65535));
      if ($urandom_range(0, 99) < 2) drain();
      send_request(mode, key, $urandom);
    end
    drain();
  endtask

  // main sequence
  initial begin
    mirror          = new();
    rst_n           = 1'b0;
    no_idle         = 1'b0;
    stall_left      = 0;
    req_ch.valid    = 1'b0;
    req_ch.mode     = MODE_GET;
    req_ch.key      = '0;
    req_ch.value    = '0;
    rsp_ch.ready    = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.capacity = lcp_pkg::CAP_RESET;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty cache, field extremes, update and miss
    send_request(MODE_GET, 16'h0000, 32'h0000_0000);
    send_request(lcp_pkg::MODE_PUT, 16'h0000, 32'h7FFF_FFFF);
    send_request(lcp_pkg::MODE_PUT, 16'hFFFF, 32'h8000_0000);
    send_request(MODE_GET, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(MODE_GET, 16'h0000, 32'h0000_0000);
    send_request(lcp_pkg::MODE_PUT, 16'h0000, 32'hFFFF_FFFF);
    send_request(MODE_GET, 16'h0000, 32'h0000_0000);
    send_request(MODE_GET, 16'h1234, 32'h0000_0000);
    send_request(lcp_pkg::MODE_PUT, 16'h5555, 32'h0000_0000);
    send_request(lcp_pkg::MODE_PUT, 16'hAAAA, 32'h5555_5555);
    drain();

    // capacity lowered below the fill count: each new key evicts one entry
    write_capacity(lcp_pkg::CAP_BITS'(2));
    send_request(lcp_pkg::MODE_PUT, 16'h0F0F, 32'h1357_9BDF);
    send_request(lcp_pkg::MODE_PUT, 16'hF0F0, 32'hECA8_6420);
    send_request(MODE_GET, 16'h0F0F, 32'h0000_0000);
    drain();

    // capacity zero: puts change nothing, gets still work
    write_capacity(lcp_pkg::CAP_BITS'(0));
    send_request(lcp_pkg::MODE_PUT, 16'h1111, 32'h2222_2222);
    send_request(lcp_pkg::MODE_PUT, 16'hFFFF, 32'h3333_3333);
    send_request(MODE_GET, 16'hFFFF, 32'h0000_0000);
    send_request(MODE_GET, 16'h1111, 32'h0000_0000);
    drain();

    // capacity above the entry count saturates
    write_capacity(lcp_pkg::CAP_BITS'(31));
    for (int i = 0; i < 6; i++)
      send_request(lcp_pkg::MODE_PUT, lcp_pkg::KEY_BITS'(16'h0100 + i), $urandom);
    drain();

    // random phases over several capacities
    write_capacity(lcp_pkg::CAP_BITS'(16));
    run_phase(150, 20, 50);
    write_capacity(lcp_pkg::CAP_BITS'(4));
    run_phase(120, 7, 50);
    write_capacity(lcp_pkg::CAP_BITS'(1));
    run_phase(80, 3, 50);
    write_capacity(lcp_pkg::CAP_BITS'(0));
    run_phase(60, 6, 60);
    write_capacity(lcp_pkg::CAP_BITS'(31));
    no_idle <= 1'b1;
    run_phase(150, 24, 50);
    no_idle <= 1'b0;
    write_capacity(lcp_pkg::CAP_BITS'($urandom_range(2, 15)));
    run_phase(150, 20, 40);
    write_capacity(lcp_pkg::CAP_BITS'(16));
    run_phase(150, 24, 40);
    write_capacity(lcp_pkg::CAP_BITS'(8));
    run_phase(140, 12, 50);

    repeat (10) @(posedge clk);
    if (mirror.errors == 0 && mirror.expected_rsp.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog
  initial begin
    #60_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- lfu_cache_policy_core.f -----
+incdir+rtl
rtl/lcp_pkg.sv
rtl/lcp_channels.sv
rtl/lcp_ctrl.sv
rtl/lcp_datapath.sv
rtl/lfu_cache_policy_core.sv
rtl/lcp_checker.sv
bench/tb_lfu_cache_policy_core.sv
